[design/ttt_pkg.sv]
// ----------------------------------------------------------------------------
// ttt_pkg
// shared types, constants and ranking compare for the topic tracker
// ----------------------------------------------------------------------------
package ttt_pkg;

  localparam int MAX_TOPICS = 256;
  localparam int TOP_K      = 3;
  localparam int TOPIC_W    = 8;
  localparam int AMT_W      = 31;
  localparam int CNT_W      = 32;
  localparam int RANK_W     = 2;
  localparam int ADDR_W     = $clog2(MAX_TOPICS);
  localparam int SCAN_W     = $clog2(MAX_TOPICS + TOP_K + 2);
  localparam int SCAN_END   = MAX_TOPICS + TOP_K + 1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                      v;
    logic signed [CNT_W-1:0]   count;
    logic        [CNT_W-1:0]   stamp;
    logic        [TOPIC_W-1:0] id;
  } cand_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  // true when a ranks above b
  function automatic logic better(cand_t a, cand_t b);
    logic r;
    if (a.count != b.count) r = (a.count > b.count);
    else if (a.stamp != b.stamp) r = (a.stamp > b.stamp);
    else r = (a.id < b.id);
    return r;
  endfunction

endpackage

[design/ttt_cell.sv]
// ----------------------------------------------------------------------------
// ttt_cell
// one rank slot: keeps the better item, hands the worse one on
// ----------------------------------------------------------------------------
module ttt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ttt_pkg::cell_ctrl_t ctrl_i,
  input  ttt_pkg::cand_t     cand_i,
  input  ttt_pkg::cand_t     right_i,
  output ttt_pkg::cand_t     held_o,
  output ttt_pkg::cand_t     pass_o
);

  ttt_pkg::cand_t held_q, held_d, pass_q, pass_d;

  always_comb begin
    held_d = held_q;
    pass_d = pass_q;
    pass_d.v = 1'b0;
    if (ctrl_i.clr) begin
      held_d.v = 1'b0;
    end else if (ctrl_i.shift) begin
      held_d = right_i;
    end else if (cand_i.v) begin
      if (!held_q.v || ttt_pkg::better(cand_i, held_q)) begin
        held_d = cand_i;
        pass_d = held_q;
      end else begin
        pass_d = cand_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign held_o = held_q;
  assign pass_o = pass_q;

endmodule

[design/ttt_chain.sv]
// ----------------------------------------------------------------------------
// ttt_chain
// row of rank cells, sorted insertion during a scan, shift-out on emit
// ----------------------------------------------------------------------------
module ttt_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttt_pkg::cell_ctrl_t ctrl_i,
  input  ttt_pkg::cand_t      cand_i,
  output ttt_pkg::cand_t      head_o,
  output logic                more_o
);

  ttt_pkg::cand_t held [ttt_pkg::TOP_K];
  ttt_pkg::cand_t pass [ttt_pkg::TOP_K];
  ttt_pkg::cand_t feed [ttt_pkg::TOP_K];
  ttt_pkg::cand_t right [ttt_pkg::TOP_K];

  for (genvar k = 0; k < ttt_pkg::TOP_K; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign feed[k] = cand_i;
    end else begin : g_rest
      assign feed[k] = pass[k-1];
    end
    if (k == ttt_pkg::TOP_K - 1) begin : g_end
      assign right[k] = '0;
    end else begin : g_mid
      assign right[k] = held[k+1];
    end
    ttt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .cand_i  (feed[k]),
      .right_i (right[k]),
      .held_o  (held[k]),
      .pass_o  (pass[k])
    );
  end

  assign head_o = held[0];
  assign more_o = right[0].v;

endmodule

[design/top_three_topic_tracker_core.sv]
// ----------------------------------------------------------------------------
// top_three_topic_tracker_core
// topic table with add, remove, clear and top-three query
// ----------------------------------------------------------------------------
// Add and remove read the table entry, then write it back in an update state;
// clear empties the table directly from idle. A query sweeps the 256-entry
// table one entry per cycle through a row of three rank cells, then drains the
// row, and then gives one result per cycle as the sink accepts them. Input is
// taken only while no item is in progress.
module top_three_topic_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // op[1:0], topic_id[9:2], amount[40:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // rank[1:0], topic_out[9:2]
  output logic        m_axis_tlast
);

  localparam int W = ttt_pkg::CNT_W;

  ttt_pkg::state_e state_q, state_d;
  logic [W-1:0] event_q, event_d;
  logic [ttt_pkg::MAX_TOPICS-1:0] present_q, present_d;
  logic [1:0] op_q;
  logic [ttt_pkg::TOPIC_W-1:0] id_q;
  logic [ttt_pkg::AMT_W-1:0] amt_q;
  logic [ttt_pkg::SCAN_W-1:0] scan_q, scan_d;
  logic [ttt_pkg::RANK_W-1:0] rank_q, rank_d;

  logic [2*W-1:0] mem [ttt_pkg::MAX_TOPICS];
  logic [2*W-1:0] rdata_q;
  logic rd_present_q;
  logic [ttt_pkg::TOPIC_W-1:0] rd_id_q;
  logic rd_live_q;
  logic [ttt_pkg::ADDR_W-1:0] rd_addr;
  logic we;
  logic [2*W-1:0] wdata;

  logic accept;
  logic [1:0] in_op;
  logic [ttt_pkg::TOPIC_W-1:0] in_id;

  ttt_pkg::cell_ctrl_t ctrl;
  ttt_pkg::cand_t cand, head;
  logic more;

  logic signed [W:0] sum;
  logic signed [W-1:0] new_count;
  logic signed [W-1:0] old_count;

  assign in_op  = s_axis_tdata[1:0];
  assign in_id  = s_axis_tdata[9:2];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ttt_pkg::ST_IDLE);

  assign rd_addr = (state_q == ttt_pkg::ST_SCAN) ? scan_q[ttt_pkg::ADDR_W-1:0] : in_id;

  always_ff @(posedge clk_i) begin
    if (we) mem[id_q] <= wdata;
    rdata_q <= mem[rd_addr];
  end

  assign old_count = rdata_q[W-1:0];

  always_comb begin
    if (op_q == ttt_pkg::OP_ADD) sum = {old_count[W-1], old_count} + {2'b00, amt_q};
    else sum = {old_count[W-1], old_count} - {2'b00, amt_q};
    if (sum[W] != sum[W-1]) new_count = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else new_count = sum[W-1:0];
    if (!present_q[id_q]) new_count = {1'b0, amt_q};
  end

  always_comb begin
    we = 1'b0;
    wdata = {rdata_q[2*W-1:W], new_count};
    if (state_q == ttt_pkg::ST_UPDATE) begin
      if (op_q == ttt_pkg::OP_ADD) begin
        we = 1'b1;
        wdata = {event_q, new_count};
      end else begin
        we = present_q[id_q];
      end
    end
  end

  assign cand.v     = rd_live_q && rd_present_q && (rdata_q[W-1:0] != '0) && !rdata_q[W-1];
  assign cand.count = rdata_q[W-1:0];
  assign cand.stamp = rdata_q[2*W-1:W];
  assign cand.id    = rd_id_q;

  always_comb begin
    state_d   = state_q;
    event_d   = event_q;
    present_d = present_q;
    scan_d    = scan_q;
    rank_d    = rank_q;
    ctrl      = '0;
    case (state_q)
      ttt_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op)
            ttt_pkg::OP_CLEAR: begin
              present_d = '0;
              event_d   = '0;
            end
            ttt_pkg::OP_QUERY: begin
              ctrl.clr = 1'b1;
              scan_d   = '0;
              rank_d   = ttt_pkg::RANK_W'(1);
              state_d  = ttt_pkg::ST_SCAN;
            end
            default: state_d = ttt_pkg::ST_UPDATE;
          endcase
        end
      end
      ttt_pkg::ST_UPDATE: begin
        if (op_q == ttt_pkg::OP_ADD) present_d[id_q] = 1'b1;
        event_d = event_q + W'(1);
        state_d = ttt_pkg::ST_IDLE;
      end
      ttt_pkg::ST_SCAN: begin
        scan_d = scan_q + ttt_pkg::SCAN_W'(1);
        if (scan_q == ttt_pkg::SCAN_W'(ttt_pkg::SCAN_END)) begin
          event_d = event_q + W'(1);
          state_d = ttt_pkg::ST_EMIT;
        end
      end
      ttt_pkg::ST_EMIT: begin
        if (!head.v) begin
          state_d = ttt_pkg::ST_IDLE;
        end else if (m_axis_tready) begin
          ctrl.shift = 1'b1;
          rank_d = rank_q + ttt_pkg::RANK_W'(1);
        end
      end
      default: state_d = ttt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttt_pkg::ST_IDLE;
      event_q   <= '0;
      present_q <= '0;
      scan_q    <= '0;
      rank_q    <= '0;
      rd_live_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      event_q   <= event_d;
      present_q <= present_d;
      scan_q    <= scan_d;
      rank_q    <= rank_d;
      rd_live_q <= (state_q == ttt_pkg::ST_SCAN) &&
                   (scan_q < ttt_pkg::SCAN_W'(ttt_pkg::MAX_TOPICS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_op;
      id_q  <= in_id;
      amt_q <= s_axis_tdata[40:10];
    end
    rd_present_q <= present_q[rd_addr];
    rd_id_q      <= rd_addr;
  end

  ttt_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cand_i (cand),
    .head_o (head),
    .more_o (more)
  );

  assign m_axis_tvalid = (state_q == ttt_pkg::ST_EMIT) && head.v;
  assign m_axis_tdata  = {6'b0, head.id, rank_q};
  assign m_axis_tlast  = !more;

  a_rank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> rank_q != '0)
    else $error("result with zero rank");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_op == ttt_pkg::OP_CLEAR |=> present_q == '0 && event_q == '0)
    else $error("clear left table populated");

  a_query_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_op == ttt_pkg::OP_QUERY |=> state_q == ttt_pkg::ST_SCAN && scan_q == '0)
    else $error("query did not start scan");

  a_event_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ttt_pkg::ST_UPDATE |=> event_q == $past(event_q) + W'(1))
    else $error("update did not advance event number");

endmodule

[sim/top_three_topic_tracker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_three_topic_tracker_core_tb
// checks add, remove, clear and top-three query results against a local
// table model, with random idle cycles on both streams and a long sink stall
// ----------------------------------------------------------------------------
module top_three_topic_tracker_core_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SNK_HOLD_LEN   = 2000;

  typedef struct {
    logic [1:0] rank;
    logic [7:0] topic;
    logic       last;
  } ranked_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic signed [31:0] mentions [ttt_pkg::MAX_TOPICS];
  logic        [31:0] stamps [ttt_pkg::MAX_TOPICS];
  bit                 known [ttt_pkg::MAX_TOPICS];
  logic        [31:0] event_cnt;
  ranked_t            ranking_q [$];

  bit errors;
  bit src_gaps = 1'b1;
  bit snk_gaps = 1'b1;
  int snk_hold = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int idle_cycles = 0;

  top_three_topic_tracker_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit outranks(int a, int b);
    if (mentions[a] != mentions[b]) return mentions[a] > mentions[b];
    if (stamps[a] != stamps[b]) return stamps[a] > stamps[b];
    return a < b;
  endfunction

  function automatic void track_event(ttt_pkg::op_e op, logic [7:0] id, logic [30:0] amt);
    longint c;
    bit taken [ttt_pkg::MAX_TOPICS];
    int best;
    int n;
    ranked_t r;
    if (op == ttt_pkg::OP_CLEAR) begin
      foreach (known[i]) known[i] = 1'b0;
      event_cnt = '0;
      return;
    end
    if (op == ttt_pkg::OP_ADD) begin
      if (!known[id]) begin
        known[id] = 1'b1;
        mentions[id] = {1'b0, amt};
      end else begin
        c = longint'(mentions[id]) + longint'(amt);
        if (c > 64'sd2147483647) c = 64'sd2147483647;
        mentions[id] = c[31:0];
      end
      stamps[id] = event_cnt;
    end else if (op == ttt_pkg::OP_REMOVE) begin
      if (known[id]) begin
        c = longint'(mentions[id]) - longint'(amt);
        if (c < -64'sd2147483648) c = -64'sd2147483648;
        mentions[id] = c[31:0];
      end
    end else begin
      n = 0;
      for (int k = 0; k < ttt_pkg::TOP_K; k++) begin
        best = -1;
        for (int t = 0; t < ttt_pkg::MAX_TOPICS; t++) begin
          if (!known[t] || taken[t] || mentions[t] <= 0) continue;
          if (best < 0 || outranks(t, best)) best = t;
        end
        if (best < 0) break;
        taken[best] = 1'b1;
        r.rank = 2'(k + 1);
        r.topic = 8'(best);
        r.last = 1'b0;
        ranking_q = {ranking_q, r};
        n++;
      end
      if (n > 0) ranking_q[$].last = 1'b1;
    end
    event_cnt = event_cnt + 1;
  endfunction

  task automatic send_event(ttt_pkg::op_e op, logic [7:0] id, logic [30:0] amt);
    while (src_gaps && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, amt, id, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_event(op, id, amt);
  endtask

  function automatic logic [30:0] rand_amount();
    case ($urandom_range(5))
      0: return 31'h7fffffff;
      1: return 31'h7fffffff - 31'($urandom_range(3));
      2: return 31'($urandom);
      default: return 31'($urandom_range(20));
    endcase
  endfunction

  task automatic test_directed();
    send_event(ttt_pkg::OP_QUERY, 8'd0, '0);
    send_event(ttt_pkg::OP_REMOVE, 8'd9, 31'd5);
    send_event(ttt_pkg::OP_ADD, 8'd0, 31'd0);
    send_event(ttt_pkg::OP_ADD, 8'd255, 31'h7fffffff);
    send_event(ttt_pkg::OP_ADD, 8'd255, 31'h7fffffff);
    send_event(ttt_pkg::OP_ADD, 8'd10, 31'd7);
    send_event(ttt_pkg::OP_ADD, 8'd20, 31'd7);
    send_event(ttt_pkg::OP_ADD, 8'd30, 31'd7);
    send_event(ttt_pkg::OP_QUERY, 8'd0, '0);
    send_event(ttt_pkg::OP_REMOVE, 8'd255, 31'h7fffffff);
    send_event(ttt_pkg::OP_REMOVE, 8'd255, 31'h7fffffff);
    send_event(ttt_pkg::OP_REMOVE, 8'd255, 31'h7fffffff);
    send_event(ttt_pkg::OP_REMOVE, 8'd0, 31'd4);
    send_event(ttt_pkg::OP_QUERY, 8'hff, 31'h7fffffff);
    send_event(ttt_pkg::OP_REMOVE, 8'd20, 31'd7);
    send_event(ttt_pkg::OP_QUERY, 8'd0, '0);
    send_event(ttt_pkg::OP_CLEAR, 8'd0, '0);
    send_event(ttt_pkg::OP_ADD, 8'd1, 31'd3);
    send_event(ttt_pkg::OP_ADD, 8'd2, 31'd3);
    send_event(ttt_pkg::OP_QUERY, 8'd0, '0);
    send_event(ttt_pkg::OP_CLEAR, 8'hff, 31'h7fffffff);
    send_event(ttt_pkg::OP_QUERY, 8'd0, '0);
  endtask

  task automatic test_random(int n_items);
    int u;
    for (int i = 0; i < n_items; i++) begin
      u = $urandom_range(99);
      if (u < 45) send_event(ttt_pkg::OP_ADD, 8'($urandom_range(15)) |
                             ($urandom_range(9) == 0 ? 8'($urandom) : 8'd0),
                             rand_amount());
      else if (u < 70) send_event(ttt_pkg::OP_REMOVE, 8'($urandom), rand_amount());
      else if (u < 97) send_event(ttt_pkg::OP_QUERY, 8'($urandom), 31'($urandom));
      else send_event(ttt_pkg::OP_CLEAR, 8'($urandom), 31'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_req = hold_req + 1;
    for (int i = 0; i < 6; i++) begin
      send_event(ttt_pkg::OP_ADD, 8'(40 + i), 31'(i + 1));
      send_event(ttt_pkg::OP_QUERY, 8'd0, '0);
    end
  endtask

  // sink side, long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      snk_hold <= SNK_HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (snk_hold > 0) begin
      snk_hold <= snk_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(snk_gaps && $urandom_range(99) < 17);
    end
  end

  always @(posedge clk_i) begin
    ranked_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (ranking_q.size() == 0) begin
        $display("%0t: unexpected result rank=%0d topic=%0d last=%0b", $time,
                 m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tlast);
        errors = 1'b1;
      end else begin
        exp_r = ranking_q.pop_front();
        if (m_axis_tdata[1:0] !== exp_r.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, exp_r.rank,
                   m_axis_tdata[1:0]);
          errors = 1'b1;
        end
        if (m_axis_tdata[9:2] !== exp_r.topic) begin
          $display("%0t: topic expected %0d actual %0d", $time, exp_r.topic,
                   m_axis_tdata[9:2]);
          errors = 1'b1;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_r.last,
                   m_axis_tlast);
          errors = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("top_three_topic_tracker_core test failed");
      $finish;
    end
  end

  initial begin
    event_cnt = '0;
    foreach (known[i]) known[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(200);
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    test_random(60);
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    test_random(180);
    s_axis_tvalid <= 1'b0;
    while (ranking_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (!errors && ranking_q.size() == 0) begin
      $display("top_three_topic_tracker_core test passed");
    end else begin
      $display("top_three_topic_tracker_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/ttt_pkg.sv
design/ttt_cell.sv
design/ttt_chain.sv
design/top_three_topic_tracker_core.sv
sim/top_three_topic_tracker_core_tb.sv
